// ----- src/sv39ptb_pkg.sv -----
`timescale 1ns / 1ps

package sv39ptb_pkg;

    // Payload widths of the request and response beats.
    localparam int VPN_W  = 27;
    localparam int PPN_W  = 44;
    localparam int CNT_W  = 19;
    localparam int PERM_W = 8;
    localparam int PTE_W  = 64;
    localparam int TIU_W  = 7;

    // Sv39 geometry: 512 entries per table page, three 9-bit VPN slices.
    localparam int IDX_W      = 9;
    localparam int PTE_PPN_LO = 10;
    localparam int PTE_PPN_HI = PTE_PPN_LO + PPN_W - 1;
    localparam int PTE_RSV_W  = PTE_W - PTE_PPN_HI - 1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 64;
    localparam logic [APB_ADDR_W-1:0] ADDR_TABLE_BASE = 3'd0;

    localparam logic [PERM_W-1:0] PTE_V_BIT = 8'h01;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOP,
        ST_RD,
        ST_CHK,
        ST_ALLOC,
        ST_LEAF,
        ST_OUT
    } t_state;

    typedef enum logic {
        LVL_ROOT,
        LVL_MID
    } t_level;

endpackage

// ----- src/sv39ptb_if.sv -----
`timescale 1ns / 1ps

interface sv39ptb_req_if
    import sv39ptb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [VPN_W-1:0]  virt_page;
    logic [PPN_W-1:0]  phys_page;
    logic [CNT_W-1:0]  page_count;
    logic [PERM_W-1:0] perm;

    modport source (output valid, virt_page, phys_page, page_count, perm, input ready);
    modport sink   (input valid, virt_page, phys_page, page_count, perm, output ready);
endinterface

interface sv39ptb_rsp_if
    import sv39ptb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             status;
    logic [CNT_W-1:0] pages_mapped;
    logic [PTE_W-1:0] last_leaf_pte;
    logic [TIU_W-1:0] tables_in_use;

    modport source (output valid, status, pages_mapped, last_leaf_pte, tables_in_use,
                    input ready);
    modport sink   (input valid, status, pages_mapped, last_leaf_pte, tables_in_use,
                    output ready);
endinterface

// ----- src/sv39ptb_store.sv -----
`timescale 1ns / 1ps

// Single-port-write, single-port-read table store with registered read data.
module sv39ptb_store
    import sv39ptb_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PTE_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [PTE_W-1:0] o_rdata
);

    logic [PTE_W-1:0] r_mem [DEPTH];
    logic [PTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sv39_page_table_builder.sv -----
// Sv39 page table builder: one request beat maps a run of page_count 4 KiB pages.
// Each page walks the root and middle levels, allocating a table page where one is
// missing, then writes the leaf; a zero count goes from ST_TOP directly to the response.
// Throughput: one run at a time; each page costs two dependent store read/check
// rounds plus a leaf write on the single store port and the shared 44-bit adder.
// Reset (synchronous, active low) starts a clearing pass over all TABLE_PAGES*512 entries.
`timescale 1ns / 1ps

module sv39_page_table_builder
    import sv39ptb_pkg::*;
#(
    parameter int TABLE_PAGES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sv39ptb_req_if.sink           i_req,
    sv39ptb_rsp_if.source         o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Pool geometry. A pool page index needs PGW bits; the allocator count must also
    // be able to hold TABLE_PAGES itself, which marks the pool as exhausted.
    localparam int PGW   = $clog2(TABLE_PAGES);
    localparam int NFW   = $clog2(TABLE_PAGES + 1);
    localparam int AW    = PGW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [NFW-1:0] POOL_FULL = NFW'(TABLE_PAGES);

    t_state r_state, n_state;
    t_level r_lvl;

    logic [AW-1:0]     r_clr_addr;
    logic [NFW-1:0]    r_next_free;
    logic [PPN_W-1:0]  r_base;

    logic [VPN_W-1:0]  r_va;
    logic [PPN_W-1:0]  r_pa;
    logic [CNT_W-1:0]  r_count;
    logic [PERM_W-1:0] r_perm;
    logic [CNT_W-1:0]  r_done;
    logic [PTE_W-1:0]  r_last;
    logic              r_status;
    logic [PGW-1:0]    r_page;

    logic [PTE_W-1:0]  w_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [PTE_W-1:0]  w_wdata;

    logic [PPN_W-1:0]  w_add_a;
    logic [PPN_W-1:0]  w_add_b;
    logic              w_add_cin;
    logic [PPN_W-1:0]  w_sum;

    logic [IDX_W-1:0]  w_idx;
    logic [PGW-1:0]    w_fresh;
    logic              w_hit;
    logic              w_full;
    logic [PTE_W-1:0]  w_leaf;
    logic [PTE_W-1:0]  w_ptr;
    logic              w_in_beat;
    logic              w_cfg_wr;
    logic [31:0]       w_nf_wide;

    // The table store holds every pool page back to back; page p starts at p*512.
    sv39ptb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Configuration: only the pool base PPN is writable. pready is tied high, so an
    // access completes without wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TABLE_BASE);
    assign prdata   = (paddr == ADDR_TABLE_BASE) ? APB_DATA_W'(r_base) : '0;

    // The VPN slice for the current level: VPN2 at the root, VPN1 one level down.
    assign w_idx   = (r_lvl == LVL_ROOT) ? r_va[VPN_W-1 -: IDX_W] : r_va[2*IDX_W-1 -: IDX_W];
    assign w_fresh = r_next_free[PGW-1:0];
    assign w_full  = (r_next_free == POOL_FULL);

    // One shared 44-bit adder serves three jobs, each in its own state: the pointer
    // check (entry PPN minus base), forming a new pointer (base plus fresh page) and
    // advancing the physical page after a leaf is written.
    assign w_sum = w_add_a + w_add_b + PPN_W'(w_add_cin);

    // A valid entry is only followed if it lands on a page that has been handed out.
    // Anything else, a stale pointer after a base change for example, is treated as
    // empty and replaced by a fresh page.
    assign w_hit = w_rdata[0] && (w_sum < PPN_W'(r_next_free));

    assign w_leaf = {{PTE_RSV_W{1'b0}}, r_pa, 2'b00, r_perm | PTE_V_BIT};
    assign w_ptr  = {{PTE_RSV_W{1'b0}}, w_sum, 2'b00, PTE_V_BIT};

    assign w_in_beat = i_req.valid && i_req.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_TOP;
                end
            end
            ST_TOP: begin
                n_state = (r_done == r_count) ? ST_OUT : ST_RD;
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (w_hit) begin
                    n_state = (r_lvl == LVL_ROOT) ? ST_RD : ST_LEAF;
                end else if (w_full) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                n_state = (r_lvl == LVL_ROOT) ? ST_RD : ST_LEAF;
            end
            ST_LEAF: begin
                n_state = ST_TOP;
            end
            ST_OUT: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Handshakes, store port and adder operand selection.
    always_comb begin
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        w_we        = 1'b0;
        w_waddr     = {r_page, w_idx};
        w_wdata     = w_ptr;
        w_raddr     = {r_page, w_idx};
        w_add_a     = r_pa;
        w_add_b     = '0;
        w_add_cin   = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_CHK: begin
                w_add_a   = w_rdata[PTE_PPN_HI:PTE_PPN_LO];
                w_add_b   = ~r_base;
                w_add_cin = 1'b1;
            end
            ST_ALLOC: begin
                w_we      = 1'b1;
                w_add_a   = r_base;
                w_add_b   = PPN_W'(w_fresh);
                w_add_cin = 1'b0;
            end
            ST_LEAF: begin
                w_we    = 1'b1;
                w_waddr = {r_page, r_va[IDX_W-1:0]};
                w_wdata = w_leaf;
            end
            ST_OUT: begin
                o_rsp.valid = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= NFW'(1);
            r_base      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == ST_ALLOC) begin
                r_next_free <= r_next_free + NFW'(1);
            end
            if (w_cfg_wr) begin
                r_base <= pwdata[PPN_W-1:0];
            end
        end
    end

    // Run state and result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    r_va     <= i_req.virt_page;
                    r_pa     <= i_req.phys_page;
                    r_count  <= i_req.page_count;
                    r_perm   <= i_req.perm;
                    r_done   <= '0;
                    r_last   <= '0;
                    r_status <= 1'b0;
                end
            end
            ST_TOP: begin
                r_lvl  <= LVL_ROOT;
                r_page <= '0;
            end
            ST_CHK: begin
                if (w_hit) begin
                    r_page <= w_sum[PGW-1:0];
                    r_lvl  <= LVL_MID;
                end else if (w_full) begin
                    r_status <= 1'b1;
                end
            end
            ST_ALLOC: begin
                r_page <= w_fresh;
                r_lvl  <= LVL_MID;
            end
            ST_LEAF: begin
                r_last <= w_leaf;
                r_done <= r_done + CNT_W'(1);
                r_va   <= r_va + VPN_W'(1);
                r_pa   <= w_sum;
            end
            default: begin
                r_lvl <= r_lvl;
            end
        endcase
    end

    assign w_nf_wide           = 32'(r_next_free);
    assign o_rsp.status        = r_status;
    assign o_rsp.pages_mapped  = r_done;
    assign o_rsp.last_leaf_pte = r_last;
    assign o_rsp.tables_in_use = w_nf_wide[TIU_W-1:0];

endmodule

// ----- src/sv39ptb_checker.sv -----
`timescale 1ns / 1ps

module sv39ptb_props
    import sv39ptb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [CNT_W-1:0] i_in_page_count,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_status,
    input logic [CNT_W-1:0] i_pages_mapped,
    input logic [PTE_W-1:0] i_last_leaf_pte
);

    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_in_valid && i_in_ready) begin
            r_count <= i_in_page_count;
        end
    end

    // Only one run is in flight, so a pending response blocks new requests.
    a_one_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request accepted while a response is pending");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after a request beat");

    // A run that did not hit pool exhaustion maps every requested page.
    a_full_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_status) |-> (i_pages_mapped == r_count))
        else $error("completed run mapped a different page count");

    a_leaf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_last_leaf_pte[PTE_W-1:PTE_PPN_HI+1] == '0)
                         && ((i_pages_mapped == '0) == (i_last_leaf_pte == '0))))
        else $error("last leaf entry inconsistent with pages mapped");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_pages_mapped) && $stable(i_last_leaf_pte)))
        else $error("response changed while stalled");

endmodule

bind sv39_page_table_builder sv39ptb_props u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_in_page_count (i_req.page_count),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_pages_mapped  (o_rsp.pages_mapped),
    .i_last_leaf_pte (o_rsp.last_leaf_pte)
);
